// ===== hw/rtl/stbs_pkg.sv =====
// Shared types and constants for the sorted table binary search block.
package stbs_pkg;

	localparam int KEY_W  = 32;
	localparam int SLOT_W = 8;
	localparam int CNT_W  = 9;

	// Item operation codes
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	typedef struct packed {
		logic                     op;
		logic [SLOT_W-1:0]        write_slot;
		logic signed [KEY_W-1:0]  key_value;
	} in_item_t;

	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] match_slot;
	} out_item_t;

	// Key table port enables
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

endpackage

// ===== hw/rtl/stbs_key_mem.sv =====
// Key table: single write port, single read port with registered read data.
module stbs_key_mem #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic                          clk,
	input  stbs_pkg::mem_ctl_t            ctl,
	input  logic [AW-1:0]                 wr_addr,
	input  logic [stbs_pkg::KEY_W-1:0]    wr_data,
	input  logic [AW-1:0]                 rd_addr,
	output logic [stbs_pkg::KEY_W-1:0]    rd_data
);
	import stbs_pkg::*;

	logic [KEY_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/stbs_search_ctrl.sv =====
// Search sequencer: accepts items, drives the key table, holds the result register.
module stbs_search_ctrl #(
	parameter int DEPTH = 256,
	parameter int AW    = 8,
	parameter int CW    = 9
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  stbs_pkg::in_item_t            in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output stbs_pkg::out_item_t           out_data,
	input  logic [stbs_pkg::CNT_W-1:0]    entry_count,
	output stbs_pkg::mem_ctl_t            mem_ctl,
	output logic [AW-1:0]                 wr_addr,
	output logic [stbs_pkg::KEY_W-1:0]    wr_data,
	output logic [AW-1:0]                 rd_addr,
	input  logic [stbs_pkg::KEY_W-1:0]    rd_data
);
	import stbs_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_PROBE = 2'd1;
	localparam logic [1:0] ST_HOLD  = 2'd2;

	logic [1:0]              state_q, state_d;
	logic signed [KEY_W-1:0] key_q, key_d;
	logic [CW-1:0]           lo_q, lo_d;
	logic [CW-1:0]           hiex_q, hiex_d;
	logic [CW-1:0]           mid_q, mid_d;
	out_item_t               res_q, res_d;
	logic                    out_valid_q, out_valid_d;
	out_item_t               out_data_q, out_data_d;

	logic [CW-1:0]           count_c;
	logic                    accept_c;
	logic                    out_free_c;
	logic signed [KEY_W-1:0] probe_c;
	logic                    eq_c, gt_c;
	logic                    a_empty_c, b_empty_c;
	logic [CW-1:0]           a_mid_c, b_lo_c, b_mid_c, init_mid_c;
	logic                    fin_c;
	out_item_t               fin_res_c;

	// clamp the entry count to the table depth
	always_comb begin
		if (32'(entry_count) > 32'(DEPTH)) begin
			count_c = CW'(DEPTH);
		end else begin
			count_c = CW'(entry_count);
		end
	end

	assign in_stall   = (state_q != ST_IDLE);
	assign accept_c   = in_valid && !in_stall;
	assign out_free_c = !out_valid_q || !out_stall;

	// probe compare and both candidate next probes, computed side by side
	assign probe_c    = signed'(rd_data);
	assign eq_c       = (probe_c == key_q);
	assign gt_c       = (probe_c > key_q);
	assign a_empty_c  = (lo_q >= mid_q);
	assign a_mid_c    = lo_q + ((mid_q - CW'(1) - lo_q) >> 1);
	assign b_lo_c     = mid_q + CW'(1);
	assign b_empty_c  = (b_lo_c >= hiex_q);
	assign b_mid_c    = b_lo_c + ((hiex_q - CW'(1) - b_lo_c) >> 1);
	assign init_mid_c = (count_c - CW'(1)) >> 1;

	// sequencer
	always_comb begin
		state_d   = state_q;
		key_d     = key_q;
		lo_d      = lo_q;
		hiex_d    = hiex_q;
		mid_d     = mid_q;
		res_d     = res_q;
		fin_c     = 1'b0;
		fin_res_c = '0;
		mem_ctl   = '0;
		wr_addr   = AW'(in_data.write_slot);
		wr_data   = in_data.key_value;
		rd_addr   = mid_q[AW-1:0];

		unique case (state_q)
			ST_IDLE: begin
				if (accept_c) begin
					if (in_data.op == OP_WRITE) begin
						// out-of-range slots are dropped
						mem_ctl.wr_en = (32'(in_data.write_slot) < 32'(DEPTH));
					end else begin
						key_d = in_data.key_value;
						if (count_c == '0) begin
							fin_c = 1'b1;
						end else begin
							lo_d          = '0;
							hiex_d        = count_c;
							mid_d         = init_mid_c;
							mem_ctl.rd_en = 1'b1;
							rd_addr       = init_mid_c[AW-1:0];
							state_d       = ST_PROBE;
						end
					end
				end
			end
			ST_PROBE: begin
				if (eq_c) begin
					fin_c                = 1'b1;
					fin_res_c.found      = 1'b1;
					fin_res_c.match_slot = SLOT_W'(mid_q);
				end else if (gt_c) begin
					// continue in the lower half
					if (a_empty_c) begin
						fin_c = 1'b1;
					end else begin
						hiex_d        = mid_q;
						mid_d         = a_mid_c;
						mem_ctl.rd_en = 1'b1;
						rd_addr       = a_mid_c[AW-1:0];
					end
				end else begin
					// continue in the upper half
					if (b_empty_c) begin
						fin_c = 1'b1;
					end else begin
						lo_d          = b_lo_c;
						mid_d         = b_mid_c;
						mem_ctl.rd_en = 1'b1;
						rd_addr       = b_mid_c[AW-1:0];
					end
				end
			end
			ST_HOLD: begin
				if (out_free_c) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// a finished search goes to the output register, or waits in HOLD
		if (fin_c) begin
			res_d   = fin_res_c;
			state_d = out_free_c ? ST_IDLE : ST_HOLD;
		end
	end

	// output register
	always_comb begin
		out_valid_d = out_valid_q;
		out_data_d  = out_data_q;
		if (out_valid_q && !out_stall) begin
			out_valid_d = 1'b0;
		end
		if (fin_c && out_free_c) begin
			out_valid_d = 1'b1;
			out_data_d  = fin_res_c;
		end else if (state_q == ST_HOLD && out_free_c) begin
			out_valid_d = 1'b1;
			out_data_d  = res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	// payload and search bounds
	always_ff @(posedge clk) begin
		key_q      <= key_d;
		lo_q       <= lo_d;
		hiex_q     <= hiex_d;
		mid_q      <= mid_d;
		res_q      <= res_d;
		out_data_q <= out_data_d;
	end

endmodule

// ===== hw/rtl/sorted_table_binary_search.sv =====
// Sorted key table with binary search lookup.
// A search makes at most floor(log2(count)) + 1 probes (9 at 256 entries) and raises
// out_valid from a register when it ends; with a count of 0 it makes no probe.
// The search runs one probe per cycle. The next item is taken in the cycle after a search
// ends, later while out_stall holds the result in HOLD. A write leaves the input unstalled.
// Reset clears the sequencer, the output valid and entry_count; the key table stays undefined.
module sorted_table_binary_search #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  stbs_pkg::in_item_t            in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output stbs_pkg::out_item_t           out_data,
	input  logic                          cfg_wr_en,
	input  logic [stbs_pkg::CNT_W-1:0]    cfg_wr_data
);
	import stbs_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic [CNT_W-1:0] cnt_q;
	mem_ctl_t         mem_ctl;
	logic [AW-1:0]    wr_addr, rd_addr;
	logic [KEY_W-1:0] wr_data, rd_data;

	// entry count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cfg_wr_en) begin
			cnt_q <= cfg_wr_data;
		end
	end

	stbs_search_ctrl #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.entry_count (cnt_q),
		.mem_ctl     (mem_ctl),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data)
	);

	stbs_key_mem #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.ctl     (mem_ctl),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// empty table search with a free output answers not found next cycle
	a_empty_miss: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.op == OP_SEARCH && cnt_q == '0 &&
		(!out_valid || !out_stall) |=> out_valid && !out_data.found)
		else $error("empty table search did not answer not found");

	// a search with entries keeps the input stalled while it probes
	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.op == OP_SEARCH && cnt_q != '0 |=> in_stall)
		else $error("input taken during a search");

	// a miss reports slot zero
	a_miss_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.found |-> out_data.match_slot == '0)
		else $error("miss with nonzero slot");

endmodule
